// ----- design/bsws_pkg.sv -----
// ----------------------------------------------------------------------------
// bsws_pkg
// Shared widths, action and status codes, and types for the bounded stack
// with search.
// ----------------------------------------------------------------------------
package bsws_pkg;

   localparam int ACT_W  = 3;
   localparam int DATA_W = 32;
   localparam int IDX_W  = 6;
   localparam int STAT_W = 3;

   // action codes
   localparam logic [ACT_W-1:0] ACT_PUSH  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_POP   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_FIND  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_READ  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
   localparam logic [STAT_W-1:0] ST_RANGE    = 3'd2;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   // control from the sequencer to the row of cells
   typedef struct packed {
      logic shift;
      logic wr;
   } row_ctl_type;

endpackage

// ----- design/bsws_if.sv -----
// ----------------------------------------------------------------------------
// bsws channel interfaces
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
interface bsws_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [bsws_pkg::ACT_W-1:0]           action;
   logic signed [bsws_pkg::DATA_W-1:0]   value;
   logic [bsws_pkg::IDX_W-1:0]           index;

   modport source (output valid, output action, output value, output index, input ready);
   modport sink   (input valid, input action, input value, input index, output ready);
endinterface

interface bsws_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [bsws_pkg::STAT_W-1:0]          status;
   logic signed [bsws_pkg::DATA_W-1:0]   data;
   logic [bsws_pkg::IDX_W-1:0]           position;

   modport source (output valid, output status, output data, output position, input ready);
   modport sink   (input valid, input status, input data, input position, output ready);
endinterface

// ----- design/bsws_cell.sv -----
// ----------------------------------------------------------------------------
// bsws_cell
// One storage cell of the ring: holds one entry and takes its neighbor's
// entry when the ring shifts.
// ----------------------------------------------------------------------------
module bsws_cell (
   input  logic                               clock,
   input  logic                               shift,
   input  logic signed [bsws_pkg::DATA_W-1:0] din,
   output logic signed [bsws_pkg::DATA_W-1:0] q
);

   logic signed [bsws_pkg::DATA_W-1:0] entry_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         entry_ff <= din;
      end
   end

   assign q = entry_ff;

endmodule

// ----- design/bsws_row.sv -----
// ----------------------------------------------------------------------------
// bsws_row
// Ring of DEPTH cells. Cell 0 is the head; on a shift every cell takes the
// entry of the next one and the last cell takes the head or a new value.
// ----------------------------------------------------------------------------
module bsws_row #(
   parameter int DEPTH = 64
) (
   input  logic                               clock,
   input  bsws_pkg::row_ctl_type              ctl,
   input  logic signed [bsws_pkg::DATA_W-1:0] wdata,
   output logic signed [bsws_pkg::DATA_W-1:0] head
);

   logic signed [bsws_pkg::DATA_W-1:0] q [DEPTH];
   logic signed [bsws_pkg::DATA_W-1:0] d [DEPTH];

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         if (i == DEPTH - 1) begin : g_tail
            // the head wraps around, or is replaced by the pushed value
            assign d[i] = ctl.wr ? wdata : q[0];
         end else begin : g_mid
            assign d[i] = q[i+1];
         end

         bsws_cell u_cell (
            .clock (clock),
            .shift (ctl.shift),
            .din   (d[i]),
            .q     (q[i])
         );
      end
   endgenerate

   assign head = q[0];

endmodule

// ----- design/bsws_ctrl.sv -----
// ----------------------------------------------------------------------------
// bsws_ctrl
// Sequencer: decodes an item, walks the ring once around for push, pop, read
// and find, keeps the entry count and holds the response register.
// ----------------------------------------------------------------------------
module bsws_ctrl #(
   parameter int DEPTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   bsws_req_if.sink                           req,
   bsws_rsp_if.source                         rsp,
   output bsws_pkg::row_ctl_type              row_ctl,
   output logic signed [bsws_pkg::DATA_W-1:0] wdata,
   input  logic signed [bsws_pkg::DATA_W-1:0] head
);

   localparam int CW   = $clog2(DEPTH + 1);
   localparam int KW   = $clog2(DEPTH);
   localparam int CMPW = (CW > bsws_pkg::IDX_W) ? CW : bsws_pkg::IDX_W;

   bsws_pkg::state_type state_ff, state_in;

   logic [CW-1:0]                      count_ff, count_in;
   logic [KW-1:0]                      k_ff, k_in;
   logic [bsws_pkg::ACT_W-1:0]         act_ff, act_in;
   logic signed [bsws_pkg::DATA_W-1:0] val_ff, val_in;
   logic [bsws_pkg::IDX_W-1:0]         idx_ff, idx_in;
   logic [bsws_pkg::STAT_W-1:0]        res_status_ff, res_status_in;
   logic signed [bsws_pkg::DATA_W-1:0] res_data_ff, res_data_in;
   logic [bsws_pkg::IDX_W-1:0]         res_pos_ff, res_pos_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [bsws_pkg::STAT_W-1:0]        rsp_status_ff, rsp_status_in;
   logic signed [bsws_pkg::DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [bsws_pkg::IDX_W-1:0]         rsp_pos_ff, rsp_pos_in;

   logic            req_ready;
   logic            accept;
   logic            load;
   logic            need_scan;
   logic            last;
   logic            full;
   logic            empty;
   logic            at_count;
   logic [CMPW-1:0] cnt_ext;
   logic [CMPW-1:0] k_ext;
   logic [CMPW-1:0] req_idx_ext;
   logic [CMPW-1:0] idx_ext;

   assign cnt_ext     = CMPW'(count_ff);
   assign k_ext       = CMPW'(k_ff);
   assign req_idx_ext = CMPW'(req.index);
   assign idx_ext     = CMPW'(idx_ff);
   assign full        = (count_ff == CW'(DEPTH));
   assign empty       = (count_ff == '0);
   assign last        = (k_ff == KW'(DEPTH - 1));
   assign at_count    = (k_ext == cnt_ext);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bsws_pkg::S_IDLE: begin
            if (accept) begin
               state_in = need_scan ? bsws_pkg::S_SCAN : bsws_pkg::S_DONE;
            end
         end
         bsws_pkg::S_SCAN: begin
            if (last) begin
               state_in = bsws_pkg::S_DONE;
            end
         end
         bsws_pkg::S_DONE: begin
            if (load) begin
               state_in = bsws_pkg::S_IDLE;
            end
         end
         default: state_in = bsws_pkg::S_IDLE;
      endcase
   end

   // handshake and ring control
   always_comb begin
      req_ready     = (state_ff == bsws_pkg::S_IDLE) && (!rsp_valid_ff || rsp.ready);
      accept        = req.valid && req_ready;
      load          = (state_ff == bsws_pkg::S_DONE) && (!rsp_valid_ff || rsp.ready);
      row_ctl.shift = (state_ff == bsws_pkg::S_SCAN);
      row_ctl.wr    = (state_ff == bsws_pkg::S_SCAN) && (act_ff == bsws_pkg::ACT_PUSH)
                      && at_count;
   end

   assign req.ready    = req_ready;
   assign wdata        = val_ff;
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.status   = rsp_status_ff;
   assign rsp.data     = rsp_data_ff;
   assign rsp.position = rsp_pos_ff;

   // datapath
   always_comb begin
      count_in      = count_ff;
      k_in          = k_ff;
      act_in        = act_ff;
      val_in        = val_ff;
      idx_in        = idx_ff;
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      res_pos_in    = res_pos_ff;
      need_scan     = 1'b0;

      if (accept) begin
         act_in        = req.action;
         val_in        = req.value;
         idx_in        = req.index;
         k_in          = '0;
         res_status_in = bsws_pkg::ST_OK;
         res_data_in   = '0;
         res_pos_in    = '0;
         unique case (req.action)
            bsws_pkg::ACT_PUSH: begin
               if (full) res_status_in = bsws_pkg::ST_FULL;
               else      need_scan     = 1'b1;
            end
            bsws_pkg::ACT_POP: begin
               if (empty) res_status_in = bsws_pkg::ST_EMPTY;
               else       need_scan     = 1'b1;
            end
            bsws_pkg::ACT_FIND: begin
               res_status_in = bsws_pkg::ST_NOTFOUND;
               need_scan     = !empty;
            end
            bsws_pkg::ACT_READ: begin
               if (req_idx_ext >= cnt_ext) res_status_in = bsws_pkg::ST_RANGE;
               else                        need_scan     = 1'b1;
            end
            bsws_pkg::ACT_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end else if (state_ff == bsws_pkg::S_SCAN) begin
         // head holds logical entry k during this step
         k_in = last ? '0 : k_ff + KW'(1);
         unique case (act_ff)
            bsws_pkg::ACT_PUSH: begin
               if (last) count_in = count_ff + CW'(1);
            end
            bsws_pkg::ACT_POP: begin
               if (k_ext == cnt_ext - CMPW'(1)) res_data_in = head;
               if (last) count_in = count_ff - CW'(1);
            end
            bsws_pkg::ACT_READ: begin
               if (k_ext == idx_ext) res_data_in = head;
            end
            bsws_pkg::ACT_FIND: begin
               if (res_status_ff == bsws_pkg::ST_NOTFOUND && k_ext < cnt_ext
                   && head == val_ff) begin
                  res_status_in = bsws_pkg::ST_OK;
                  res_pos_in    = k_ext[bsws_pkg::IDX_W-1:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_pos_in    = rsp_pos_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_data_in   = res_data_ff;
         rsp_pos_in    = res_pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsws_pkg::S_IDLE;
         count_ff     <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      res_pos_ff    <= res_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_pos_ff    <= rsp_pos_in;
   end

endmodule

// ----- design/bounded_stack_with_search_top.sv -----
// flow: push, pop, read and a find on a non-empty store walk the ring in S_SCAN, then
//   load the response in S_DONE; clear, unknown actions and error cases skip S_SCAN
// items: a new item is taken only in S_IDLE, after the walk for the last one, a full
//   turn of the cell ring, which returns entry 0 to the head after every walk
// reset: clears the entry count and the response valid; entries are not reset
// ----------------------------------------------------------------------------
// bounded_stack_with_search_top
// Fixed-capacity stack with push, pop, find, indexed read and clear, built
// as a rotating ring of storage cells and a small sequencer.
// ----------------------------------------------------------------------------
module bounded_stack_with_search_top #(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   bsws_req_if.sink    req_chan,
   bsws_rsp_if.source  rsp_chan
);

   bsws_pkg::row_ctl_type              row_ctl;
   logic signed [bsws_pkg::DATA_W-1:0] wdata;
   logic signed [bsws_pkg::DATA_W-1:0] head;

   bsws_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .rsp     (rsp_chan),
      .row_ctl (row_ctl),
      .wdata   (wdata),
      .head    (head)
   );

   bsws_row #(
      .DEPTH (DEPTH)
   ) u_row (
      .clock (clock),
      .ctl   (row_ctl),
      .wdata (wdata),
      .head  (head)
   );

endmodule
